### rtl/lna_pkg.sv
// Shared types and constants for the landmark association block.
package lna_pkg;

  localparam int LANDMARKS = 64;
  localparam int ADDR_W    = $clog2(LANDMARKS);
  localparam int CNT_W     = $clog2(LANDMARKS + 1);
  localparam int CFG_IDX_W = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W    = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_POSE_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POSE_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POSE_COS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POSE_SIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_SQ = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL    = 3'd5;

  localparam logic REQ_LOAD      = 1'b0;
  localparam logic REQ_ASSOCIATE = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [5:0]         slot;
    logic [15:0]        mark_id;
    logic signed [31:0] mark_x;
    logic signed [31:0] mark_y;
    logic [15:0]        obs_id;
    logic signed [31:0] obs_x;
    logic signed [31:0] obs_y;
  } req_t;

  typedef struct packed {
    logic [15:0]        tag;
    logic signed [31:0] map_x;
    logic signed [31:0] map_y;
    logic               found;
    logic [15:0]        nearest_id;
    logic [63:0]        nearest_dist_sq;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] pose_cos;
    logic signed [15:0] pose_sin;
    logic [63:0]        range_sq;
    logic [6:0]         landmark_total;
  } cfg_t;

  // Classified word handed from the front part to the back part.
  typedef struct packed {
    logic               req_type;
    logic [5:0]         slot;
    logic [15:0]        mark_id;
    logic signed [31:0] mark_x;
    logic signed [31:0] mark_y;
    logic [15:0]        tag;
    logic signed [31:0] map_x;
    logic signed [31:0] map_y;
  } q_item_t;

  // One landmark table entry.
  typedef struct packed {
    logic [15:0]        id;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } mark_t;

  localparam int MARK_W = $bits(mark_t);

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_SUM
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_DRAIN
  } back_state_t;

endpackage

### rtl/lna_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/lna_front.sv
// Front part: takes request words and maps observations into the map frame.
module lna_front import lna_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  req_t    req,
  input  cfg_t    cfg,
  input  logic    q_full,
  output logic    q_push,
  output q_item_t q_item
);

  front_state_t state, state_next;
  req_t item;
  logic signed [47:0] p_cx, p_sy, p_sx, p_cy;
  logic accept;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
      return v[31:0];
    end
    return v[35] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  logic signed [35:0] sum_x, sum_y;

  // Products are floored by an arithmetic shift before the sums.
  always_comb begin
    sum_x = 36'(cfg.pose_x) + 36'(p_cx >>> 14) - 36'(p_sy >>> 14);
    sum_y = 36'(cfg.pose_y) + 36'(p_sx >>> 14) + 36'(p_cy >>> 14);
  end

  always_comb begin
    state_next = state;
    q_push     = 1'b0;
    busy       = 1'b1;
    case (state)
      F_IDLE: begin
        busy = 1'b0;
      end
      F_MUL: begin
        state_next = F_SUM;
      end
      F_SUM: begin
        if (!q_full) begin
          q_push     = 1'b1;
          busy       = 1'b0;
          state_next = F_IDLE;
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
    accept = start && !busy;
    if (accept) begin
      state_next = F_MUL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
    if (state == F_MUL) begin
      p_cx <= cfg.pose_cos * item.obs_x;
      p_sy <= cfg.pose_sin * item.obs_y;
      p_sx <= cfg.pose_sin * item.obs_x;
      p_cy <= cfg.pose_cos * item.obs_y;
    end
  end

  always_comb begin
    q_item.req_type = item.req_type;
    q_item.slot     = item.slot;
    q_item.mark_id  = item.mark_id;
    q_item.mark_x   = item.mark_x;
    q_item.mark_y   = item.mark_y;
    q_item.tag      = item.obs_id;
    q_item.map_x    = sat32(sum_x);
    q_item.map_y    = sat32(sum_y);
  end

endmodule

### rtl/lna_queue.sv
// Short queue of classified words between the front and back parts.
module lna_queue import lna_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    empty,
  output q_item_t head
);

  q_item_t entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full  = (fill == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

### rtl/lna_back.sv
// Back part: landmark table writes and the pipelined nearest-landmark scan.
module lna_back import lna_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_empty,
  input  q_item_t q_head,
  output logic    q_pop,
  output logic    done,
  output rsp_t    rsp
);

  back_state_t state, state_next;

  logic [CNT_W-1:0] idx, scan_cnt, start_cnt;
  logic issue, table_we, scan_start, emit, pipe_busy;
  mark_t wr_mark, rd_mark;

  // Observation held during its scan, and the running best.
  logic [15:0]        cur_tag;
  logic signed [31:0] cur_x, cur_y;
  logic               found;
  logic [15:0]        best_id;
  logic [63:0]        best_d;

  // Scan pipeline: table read, differences, squares, sums.
  logic        v1, v2, v3, v4;
  logic [31:0] pdx, pdy, odx, ody;
  logic [15:0] id2, id3, id4;
  logic [63:0] ppx, ppy, pox, poy;
  logic [63:0] pd, od;

  function automatic logic [31:0] abs_diff(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    return d[32] ? 32'(-d) : d[31:0];
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  assign start_cnt = (32'(cfg.landmark_total) > 32'(LANDMARKS)) ?
                     CNT_W'(LANDMARKS) : CNT_W'(cfg.landmark_total);
  assign pipe_busy = v1 || v2 || v3 || v4;

  always_comb begin
    wr_mark.id = q_head.mark_id;
    wr_mark.x  = q_head.mark_x;
    wr_mark.y  = q_head.mark_y;
  end

  lna_ram #(
    .WIDTH(MARK_W),
    .DEPTH(LANDMARKS)
  ) u_table (
    .clk  (clk),
    .we   (table_we),
    .waddr(ADDR_W'(q_head.slot)),
    .wdata(wr_mark),
    .raddr(idx[ADDR_W-1:0]),
    .rdata(rd_mark)
  );

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    table_we   = 1'b0;
    scan_start = 1'b0;
    issue      = 1'b0;
    emit       = 1'b0;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.req_type == REQ_LOAD) begin
            table_we = (32'(q_head.slot) < 32'(LANDMARKS));
          end else begin
            scan_start = 1'b1;
            state_next = (start_cnt == '0) ? B_DRAIN : B_SCAN;
          end
        end
      end
      B_SCAN: begin
        issue = 1'b1;
        if (idx == scan_cnt - 1'b1) begin
          state_next = B_DRAIN;
        end
      end
      B_DRAIN: begin
        if (!pipe_busy) begin
          emit       = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= issue;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      done <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      idx      <= '0;
      scan_cnt <= start_cnt;
      cur_tag  <= q_head.tag;
      cur_x    <= q_head.map_x;
      cur_y    <= q_head.map_y;
      found    <= 1'b0;
      best_id  <= '0;
      best_d   <= '0;
    end else begin
      if (issue) begin
        idx <= idx + 1'b1;
      end
      // The first strict minimum among in-range entries is kept.
      if (v4 && pd <= cfg.range_sq && (!found || od < best_d)) begin
        found   <= 1'b1;
        best_id <= id4;
        best_d  <= od;
      end
    end

    pdx <= abs_diff(cfg.pose_x, rd_mark.x);
    pdy <= abs_diff(cfg.pose_y, rd_mark.y);
    odx <= abs_diff(cur_x, rd_mark.x);
    ody <= abs_diff(cur_y, rd_mark.y);
    id2 <= rd_mark.id;

    ppx <= pdx * pdx;
    ppy <= pdy * pdy;
    pox <= odx * odx;
    poy <= ody * ody;
    id3 <= id2;

    pd  <= sat_add(ppx, ppy);
    od  <= sat_add(pox, poy);
    id4 <= id3;

    if (emit) begin
      rsp.tag             <= cur_tag;
      rsp.map_x           <= cur_x;
      rsp.map_y           <= cur_y;
      rsp.found           <= found;
      rsp.nearest_id      <= best_id;
      rsp.nearest_dist_sq <= best_d;
    end
  end

endmodule

### rtl/landmark_nearest_association.sv
// Top level of the nearest-landmark association block with its configuration registers.
//
// Usage: a request word is taken on req at a rising edge where start is high and
// busy is low. A word with req_type LOAD writes one landmark (id, x, y) into table
// slot slot and gives no result. A word with req_type ASSOCIATE rotates and shifts
// the observation into the map frame and scans the first landmark_total table
// entries (at most 64), returning one result word on rsp, marked by done for
// exactly one cycle. The receiver cannot stall that word; it must take it.
// Configuration registers are written over the cfg_valid / cfg_ready channel
// (cfg_ready is always high), indexed by cfg_index. The user must write them
// only while the block is idle; the block itself does not enforce this.
// The front part multiplies, then adds and saturates each word, and hands it
// into a two-entry queue. The back part writes a load from its idle state; an
// association scans the first N entries, N being the clamped landmark count,
// then drains its pipeline before the result, or drains at once when N is zero.
// The single read port of the landmark table gives one entry per cycle, and this
// sets the throughput. The front keeps taking words while the back scans, until
// the queue fills. Reset clears the queue, both control sequencers and the
// registers to their defaults; the landmark table holds no meaning until loaded.
module landmark_nearest_association import lna_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 req,
  output logic                 done,
  output rsp_t                 rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  cfg_t    cfg;
  logic    q_full, q_push, q_empty, q_pop;
  q_item_t q_item, q_head;

  assign cfg_ready = 1'b1;

  // Register file; writes to indexes past the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pose_x         <= '0;
      cfg.pose_y         <= '0;
      cfg.pose_cos       <= 16'sd16384;
      cfg.pose_sin       <= '0;
      cfg.range_sq       <= '0;
      cfg.landmark_total <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POSE_X:   cfg.pose_x         <= cfg_data[31:0];
        REG_POSE_Y:   cfg.pose_y         <= cfg_data[31:0];
        REG_POSE_COS: cfg.pose_cos       <= cfg_data[15:0];
        REG_POSE_SIN: cfg.pose_sin       <= cfg_data[15:0];
        REG_RANGE_SQ: cfg.range_sq       <= cfg_data;
        REG_TOTAL:    cfg.landmark_total <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // Front part: accepts words and computes map coordinates.
  lna_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .cfg   (cfg),
    .q_full(q_full),
    .q_push(q_push),
    .q_item(q_item)
  );

  // The queue keeps load and associate words in their arrival order.
  lna_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_item(q_item),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Back part: owns the landmark table and the distance scan.
  lna_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .q_empty(q_empty),
    .q_head (q_head),
    .q_pop  (q_pop),
    .done   (done),
    .rsp    (rsp)
  );

endmodule

### test/tb.sv
// Self-checking testbench for landmark_nearest_association.
`timescale 1ns / 1ps

module tb;
  import lna_pkg::*;

  // No new phase of words starts once this many have been accepted.
  localparam int ITEM_TARGET = 1750;
  // Covers the front part, the two-entry queue and one full scan, with margin.
  localparam int DRAIN_CYCLES = 100;
  // The index field is 3 bits wide, so two indexes map to no register at all.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [15:0] Q14_ONE   = 16'sd16384;
  localparam logic signed [15:0] Q14_ZERO  = 16'sd0;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  req_t                 req = '0;
  logic                 done;
  rsp_t                 rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data = '0;

  landmark_nearest_association i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the block: its registers, its landmark table and the matches it
  // still owes us. Loads only update the table; each association word is
  // resolved at the moment it is accepted, since registers never change while
  // words are in flight and the block works through its words in order.
  class association_tracker;
    logic signed [31:0] pose_x = '0;
    logic signed [31:0] pose_y = '0;
    logic signed [15:0] pose_cos = 16'sd16384;
    logic signed [15:0] pose_sin = '0;
    logic [63:0]        range_sq = '0;
    logic [6:0]         mark_total = '0;
    logic signed [31:0] mark_x [LANDMARKS];
    logic signed [31:0] mark_y [LANDMARKS];
    logic [15:0]        mark_id [LANDMARKS];
    rsp_t               expected_matches [$];
    int                 failures = 0;

    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
        REG_POSE_X:   pose_x = data[31:0];
        REG_POSE_Y:   pose_y = data[31:0];
        REG_POSE_COS: pose_cos = data[15:0];
        REG_POSE_SIN: pose_sin = data[15:0];
        REG_RANGE_SQ: range_sq = data;
        REG_TOTAL:    mark_total = data[6:0];
        default:      ;
      endcase
    endfunction

    function logic signed [31:0] clamp32(longint v);
      if (v > longint'(COORD_MAX)) return COORD_MAX;
      if (v < longint'(COORD_MIN)) return COORD_MIN;
      return v[31:0];
    endfunction

    // Differences of two 32-bit coordinates stay below 2^32, so each square fits
    // in 64 bits; only the sum can spill over, and then it pins at all ones.
    function logic [63:0] sq_dist(longint ax, longint ay, longint bx, longint by);
      longint      dx;
      longint      dy;
      logic [63:0] ux;
      logic [63:0] uy;
      logic [64:0] total_sq;
      dx = ax - bx;
      dy = ay - by;
      ux = (dx < 0) ? -dx : dx;
      uy = (dy < 0) ? -dy : dy;
      total_sq = {1'b0, ux * ux} + {1'b0, uy * uy};
      return total_sq[64] ? '1 : total_sq[63:0];
    endfunction

    function rsp_t predict_match(req_t w);
      rsp_t        r;
      longint      c;
      longint      s;
      longint      ox;
      longint      oy;
      longint      px;
      longint      py;
      logic [63:0] d;
      int          n;
      int          i;
      c  = longint'(pose_cos);
      s  = longint'(pose_sin);
      ox = longint'(w.obs_x);
      oy = longint'(w.obs_y);
      px = longint'(pose_x);
      py = longint'(pose_y);
      // Arithmetic right shifts of the Q2.14 products floor toward minus infinity.
      r.tag   = w.obs_id;
      r.map_x = clamp32(px + ((c * ox) >>> 14) - ((s * oy) >>> 14));
      r.map_y = clamp32(py + ((s * ox) >>> 14) + ((c * oy) >>> 14));
      r.found = 1'b0;
      r.nearest_id = '0;
      r.nearest_dist_sq = '0;
      // A count above the table depth scans the whole table once.
      n = (mark_total > LANDMARKS) ? LANDMARKS : int'(mark_total);
      for (i = 0; i < n; i++) begin
        if (sq_dist(px, py, longint'(mark_x[i]), longint'(mark_y[i])) <= range_sq) begin
          d = sq_dist(longint'(r.map_x), longint'(r.map_y),
                      longint'(mark_x[i]), longint'(mark_y[i]));
          // Strictly smaller only, so the lowest slot keeps a tie.
          if (!r.found || d < r.nearest_dist_sq) begin
            r.found = 1'b1;
            r.nearest_dist_sq = d;
            r.nearest_id = mark_id[i];
          end
        end
      end
      return r;
    endfunction

    function void note_request(req_t w);
      if (w.req_type == REQ_LOAD) begin
        mark_id[w.slot] = w.mark_id;
        mark_x[w.slot]  = w.mark_x;
        mark_y[w.slot]  = w.mark_y;
      end else begin
        expected_matches.insert(expected_matches.size(), predict_match(w));
      end
    endfunction

    function void compare_field(string name, logic [15:0] tag, logic [63:0] want,
                                logic [63:0] got);
      if (got !== want) begin
        failures++;
        if (failures <= 10)
          $display("%0t: %s mismatch, tag %h: expected %h, actual %h",
                   $time, name, tag, want, got);
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_matches.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result word with nothing predicted, tag %h", $time, got.tag);
        return;
      end
      want = expected_matches.pop_front();
      compare_field("tag", want.tag, 64'(want.tag), 64'(got.tag));
      compare_field("map_x", want.tag, 64'(want.map_x), 64'(got.map_x));
      compare_field("map_y", want.tag, 64'(want.map_y), 64'(got.map_y));
      compare_field("found", want.tag, 64'(want.found), 64'(got.found));
      compare_field("nearest_id", want.tag, 64'(want.nearest_id), 64'(got.nearest_id));
      compare_field("nearest_dist_sq", want.tag, want.nearest_dist_sq, got.nearest_dist_sq);
    endfunction

    function int pending();
      return expected_matches.size();
    endfunction
  endclass

  association_tracker board;
  int words_sent = 0;
  int burst_left = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Result words cannot be held off, so every cycle with done high is one
  // accepted word. Values are read as they stood before the edge.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) board.check_result(rsp);
  end

  // Hard stop in case the block hangs.
  initial begin
    #(4_000_000);
    $display("TEST FAILED");
    $finish;
  end

  // Mostly short bursts, now and then a long stretch with no gaps at all.
  function automatic int pick_burst();
    if ($urandom_range(0, 4) == 0) return $urandom_range(15, 40);
    return $urandom_range(1, 6);
  endfunction

  // Long gaps let the back part finish a scan and go idle; short ones land
  // in the middle of a scan or while the queue is filling.
  function automatic int pick_gap();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(30, 90);
      1:       return 0;
      default: return $urandom_range(1, 5);
    endcase
  endfunction

  // Fields that the chosen operation does not use still carry random bits.
  function automatic req_t noise_word();
    logic [191:0] bits;
    bits = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    return bits[$bits(req_t)-1:0];
  endfunction

  function automatic req_t load_word(logic [5:0] slot, logic [15:0] id,
                                     logic signed [31:0] x, logic signed [31:0] y);
    req_t w;
    w = noise_word();
    w.req_type = REQ_LOAD;
    w.slot     = slot;
    w.mark_id  = id;
    w.mark_x   = x;
    w.mark_y   = y;
    return w;
  endfunction

  function automatic req_t observe_word(logic [15:0] tag, logic signed [31:0] x,
                                        logic signed [31:0] y);
    req_t w;
    w = noise_word();
    w.req_type = REQ_ASSOCIATE;
    w.obs_id   = tag;
    w.obs_x    = x;
    w.obs_y    = y;
    return w;
  endfunction

  // A coordinate within +/- span of center; wraps if the center sits near an edge.
  function automatic logic signed [31:0] near(logic signed [31:0] center, int span);
    longint v;
    v = longint'(center) + longint'($urandom_range(0, 2 * span)) - longint'(span);
    return v[31:0];
  endfunction

  // Hands one word over. start stays high across a burst so back-to-back words
  // go in on consecutive free cycles; it only drops for a real gap.
  task automatic send_word(req_t w);
    int gap;
    start <= 1'b1;
    req   <= w;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_request(w);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = pick_burst();
      gap = pick_gap();
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop sending, let every owed match come back, then give trailing loads
  // time to leave the queue before any register is touched.
  task automatic wait_idle();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // cfg_valid stays high across a run of writes and is dropped by the caller.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    board.apply_write(idx, data);
  endtask

  // Writes every register, with junk above the narrow ones, plus both unused
  // indexes, which must leave everything as it was.
  task automatic program_pose(logic signed [31:0] px, logic signed [31:0] py,
                              logic signed [15:0] c, logic signed [15:0] s,
                              logic [63:0] rsq, logic [6:0] total);
    cfg_write(REG_SPARE_A, {$urandom(), $urandom()});
    cfg_write(REG_POSE_X, {$urandom(), px});
    cfg_write(REG_POSE_Y, {$urandom(), py});
    cfg_write(REG_POSE_COS, {$urandom(), 16'($urandom()), c});
    cfg_write(REG_POSE_SIN, {$urandom(), 16'($urandom()), s});
    cfg_write(REG_RANGE_SQ, rsq);
    cfg_write(REG_TOTAL, {$urandom(), 25'($urandom()), total});
    cfg_write(REG_SPARE_B, {$urandom(), $urandom()});
    cfg_valid <= 1'b0;
  endtask

  // One random setting of the pose followed by a mix of loads and observations.
  // Landmarks are mostly dropped around the pose at about one and a half times
  // the sensor range, so a good share falls inside it and a good share outside.
  task automatic run_phase(int words);
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] c;
    logic signed [15:0] s;
    logic [63:0]        rsq;
    logic [6:0]         total;
    int                 r;
    int                 span;
    int                 j;
    int                 k;
    real                angle;
    req_t               w;

    case ($urandom_range(0, 9))
      8: begin
        px = $urandom();
        py = $urandom();
      end
      9: begin
        px = near(COORD_MAX, 1 << 20);
        py = near(COORD_MIN, 1 << 20);
      end
      default: begin
        px = near(0, 1 << 22);
        py = near(0, 1 << 22);
      end
    endcase

    case ($urandom_range(0, 7))
      6: begin
        c = 16'($urandom_range(0, 32768) - 16384);
        s = 16'($urandom_range(0, 32768) - 16384);
      end
      7: begin
        c = ($urandom_range(0, 1) != 0) ? Q14_ONE : -Q14_ONE;
        s = ($urandom_range(0, 1) != 0) ? Q14_ONE : -Q14_ONE;
      end
      default: begin
        angle = $urandom_range(0, 35999) * 3.14159265358979 / 18000.0;
        c = 16'($rtoi(16384.0 * $cos(angle)));
        s = 16'($rtoi(16384.0 * $sin(angle)));
      end
    endcase

    r = $urandom_range(1 << 14, 1 << 22);
    case ($urandom_range(0, 9))
      0:       rsq = '0;
      1:       rsq = '1;
      2:       rsq = {$urandom(), $urandom()};
      default: rsq = longint'(r) * longint'(r);
    endcase

    case ($urandom_range(0, 7))
      0:       total = '0;
      1:       total = 7'($urandom_range(LANDMARKS + 1, 127));
      2:       total = 7'(LANDMARKS);
      default: total = 7'($urandom_range(1, LANDMARKS));
    endcase

    program_pose(px, py, c, s, rsq, total);
    span = r + r / 2;

    for (k = 0; k < words; k++) begin
      if ($urandom_range(0, 9) < 3) begin
        j = $urandom_range(0, LANDMARKS - 1);
        case ($urandom_range(0, 7))
          0: w = load_word(6'($urandom()), 16'($urandom()), $urandom(), $urandom());
          // Same spot as another slot, so equal distances compete.
          1: w = load_word(6'($urandom()), 16'($urandom()), board.mark_x[j],
                           board.mark_y[j]);
          default: w = load_word(6'($urandom()), 16'($urandom()), near(px, span),
                                 near(py, span));
        endcase
      end else begin
        if ($urandom_range(0, 7) == 0)
          w = observe_word(16'($urandom()), $urandom(), $urandom());
        else
          w = observe_word(16'($urandom()), near(0, r), near(0, r));
      end
      send_word(w);
    end
    wait_idle();
  endtask

  initial begin
    int k;
    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    burst_left = pick_burst();

    // Reset state: identity heading, no landmarks counted, so nothing is found
    // and the observation comes back unchanged.
    send_word(observe_word(16'h0001, COORD_MAX, COORD_MIN));
    wait_idle();

    // Pose in opposite corners of the map, 45 degree heading with both trig
    // values at full scale, unlimited range. Transformed coordinates pin at
    // the edges and distances overflow to all ones. Slots two and three sit on
    // the same point, so the lower one has to win the tie.
    program_pose(COORD_MAX, COORD_MIN, Q14_ONE, Q14_ONE, '1, 7'd4);
    send_word(load_word(6'd0, 16'hFFFF, COORD_MAX, COORD_MIN));
    send_word(load_word(6'd1, 16'h0000, COORD_MIN, COORD_MAX));
    send_word(load_word(6'd2, 16'h0001, '0, '0));
    send_word(load_word(6'd3, 16'h0002, '0, '0));
    send_word(observe_word(16'hFFFF, COORD_MAX, COORD_MAX));
    send_word(observe_word(16'h0000, COORD_MIN, COORD_MIN));
    send_word(observe_word(16'h00A5, COORD_MAX, COORD_MIN));
    send_word(observe_word(16'h005A, COORD_MIN, COORD_MAX));
    send_word(observe_word(16'h1234, '0, '0));
    wait_idle();

    // Heading of 225 degrees at the origin with zero range: only the two
    // landmarks sitting exactly on the pose count, and they tie.
    program_pose('0, '0, -Q14_ONE, -Q14_ONE, '0, 7'd4);
    send_word(observe_word(16'h2000, '0, '0));
    send_word(observe_word(16'h2001, COORD_MIN, COORD_MAX));
    send_word(observe_word(16'h2002, 32'sd12345, -32'sd6789));
    wait_idle();

    // Range boundary: a landmark one metre out is in range at exactly one
    // square metre and out of range one step below it.
    program_pose('0, '0, Q14_ONE, Q14_ZERO, 64'h0000_0001_0000_0000, 7'd4);
    send_word(load_word(6'd3, 16'h0003, 32'sh0001_0000, '0));
    send_word(observe_word(16'h3000, 32'sh0001_0000, '0));
    wait_idle();
    program_pose('0, '0, Q14_ONE, Q14_ZERO, 64'h0000_0000_FFFF_FFFF, 7'd4);
    send_word(observe_word(16'h3001, 32'sh0001_0000, '0));
    wait_idle();

    // Fill the whole table so any count is safe from here on, and scan it
    // with a count far beyond the table depth.
    program_pose('0, '0, Q14_ONE, Q14_ZERO, 64'h0000_4000_0000_0000, 7'h7F);
    for (k = 0; k < LANDMARKS; k++)
      send_word(load_word(k[5:0], 16'($urandom()), near(0, 1 << 22), near(0, 1 << 22)));
    for (k = 0; k < 8; k++)
      send_word(observe_word(16'($urandom()), near(0, 1 << 22), near(0, 1 << 22)));
    wait_idle();

    while (words_sent < ITEM_TARGET)
      run_phase($urandom_range(10, 60));

    wait_idle();
    if (board.failures == 0 && board.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

### files.f
rtl/lna_pkg.sv
rtl/lna_ram.sv
rtl/lna_front.sv
rtl/lna_queue.sv
rtl/lna_back.sv
rtl/landmark_nearest_association.sv
test/tb.sv
